[rtl/core/sleep_wakeup_table_top_assert.svh]
// Assertion macros for the sleep/wakeup table.
`ifndef SLEEP_WAKEUP_TABLE_TOP_ASSERT_SVH
`define SLEEP_WAKEUP_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every edge outside reset.
`define SWT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define SWT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SWT_ASSERT(label, clk, rst_n, prop, msg)
`define SWT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[rtl/core/swt_pkg.sv]
// Types, codes and sizes shared by the sleep/wakeup table.
package swt_pkg;

    localparam int MAX_SLEEPERS = 16;
    localparam int RESULT_CAP   = 16;

    localparam int CNT_W  = $clog2(MAX_SLEEPERS + 1);
    localparam int IDX_W  = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
    localparam int WOKE_W = $clog2(RESULT_CAP + 1);

    localparam int TICK_W = 48;
    localparam int LEN_W  = 32;
    localparam int THR_W  = 8;
    localparam int PRI_W  = 6;
    localparam int QUA_W  = 16;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 88;

    // command codes (input tuser)
    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // result kinds (output tuser)
    localparam logic [1:0] KIND_SLEEP     = 2'd0;
    localparam logic [1:0] KIND_WOKEN     = 2'd1;
    localparam logic [1:0] KIND_IDLE_TICK = 2'd2;

    // sleep status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_ZERO    = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;

    typedef struct packed {
        logic [THR_W-1:0]  thread;
        logic [TICK_W-1:0] wake;
        logic [PRI_W-1:0]  pri;
        logic [QUA_W-1:0]  qua;
    } t_slot;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [THR_W-1:0]  thread;
        logic              rv;
        logic [PRI_W-1:0]  pri;
        logic [QUA_W-1:0]  qua;
        logic [TICK_W-1:0] tick;
        logic              last;
    } t_result;

endpackage

[rtl/core/sleep_wakeup_table_top.sv]
// Sleep/wakeup table: tick counter, packed sleeper table and wake scan.
//
//  channel  | dir | handshake                         | carries
//  ---------+-----+-----------------------------------+--------------------------------
//  s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready | sleep or tick request
//  m_axis   | out | o_m_axis_tvalid / i_m_axis_tready | status, woken threads, idle tick
//  cfg      | in  | i_cfg_valid / o_cfg_ready         | mlfq_mode bit
//
// A sleep request is answered from the idle state with no scan. A tick request first bumps
// the counter, then takes one step per used slot plus a closing step, all through the
// single 49-bit adder that also does the wake compare. Scan steps pause while the
// output register is held by the sink. Reset is synchronous; the table needs no
// clearing pass, only the fill count is cleared.
module sleep_wakeup_table_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // thread_id[7:0], sleep_ticks[39:8], saved_priority[45:40], saved_quantum[61:46]
    input  logic [swt_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // command[0]
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // status[1:0], woken_thread[9:2], restore_valid[10], restored_priority[16:11],
    // restored_quantum[32:17], current_tick[80:33]
    output logic [swt_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                       o_m_axis_tuser,
    output logic                             o_m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_data
);
    import swt_pkg::*;

    `include "sleep_wakeup_table_top_assert.svh"

    typedef enum logic {ST_IDLE, ST_SCAN} t_state;

    t_state             r_state, n_state;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_wr, n_wr;
    logic [WOKE_W-1:0]  r_nwoke, n_nwoke;
    logic               r_mode, n_mode;
    logic               r_pend_valid, n_pend_valid;
    t_result            r_pend, n_pend;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    t_slot              r_slot [MAX_SLEEPERS];

    // slot write port
    logic               slot_we;
    logic [IDX_W-1:0]   slot_wa;
    t_slot              slot_wd;

    // shared adder / compare unit
    logic [TICK_W-1:0]  alu_b;
    logic               alu_cin;
    logic [TICK_W:0]    alu_sum;

    logic               out_free;
    logic               in_acc;
    logic [LEN_W-1:0]   in_len;
    t_slot              cur;
    logic               due;
    t_result            woke;

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign in_len = i_s_axis_tdata[39:8];
    assign o_cfg_ready = 1'b1;

    assign cur = r_slot[r_idx[IDX_W-1:0]];

    always_comb begin
        alu_b   = '0;
        alu_cin = 1'b0;
        if (r_state == ST_SCAN) begin
            alu_b   = ~cur.wake;      // r_tick - wake: carry out means due
            alu_cin = 1'b1;
        end else if (i_s_axis_tuser == CMD_TICK) begin
            alu_cin = 1'b1;
        end else begin
            alu_b = {{(TICK_W-LEN_W){1'b0}}, in_len};
        end
    end

    assign alu_sum = {1'b0, r_tick} + {1'b0, alu_b} + {{TICK_W{1'b0}}, alu_cin};
    assign due = alu_sum[TICK_W];

    always_comb begin
        woke        = '0;
        woke.kind   = KIND_WOKEN;
        woke.thread = cur.thread;
        woke.rv     = r_mode;
        woke.pri    = r_mode ? cur.pri : '0;
        woke.qua    = r_mode ? cur.qua : '0;
    end

    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_count      = r_count;
        n_idx        = r_idx;
        n_wr         = r_wr;
        n_nwoke      = r_nwoke;
        n_mode       = r_mode;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out        = r_out;
        slot_we      = 1'b0;
        slot_wa      = r_count[IDX_W-1:0];
        slot_wd      = cur;

        if (i_cfg_valid) begin
            n_mode = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_axis_tuser == CMD_TICK) begin
                        n_tick       = alu_sum[TICK_W-1:0];
                        n_idx        = '0;
                        n_wr         = '0;
                        n_nwoke      = '0;
                        n_pend_valid = 1'b0;
                        n_state      = ST_SCAN;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.kind  = KIND_SLEEP;
                        n_out.tick  = r_tick;
                        n_out.last  = 1'b1;
                        if (in_len == '0) begin
                            n_out.status = STS_ZERO;
                        end else if (r_count == CNT_W'(MAX_SLEEPERS)) begin
                            n_out.status = STS_FULL;
                        end else begin
                            n_out.status   = STS_OK;
                            slot_we        = 1'b1;
                            slot_wd.thread = i_s_axis_tdata[7:0];
                            slot_wd.wake   = alu_sum[TICK_W-1:0];
                            slot_wd.pri    = i_s_axis_tdata[45:40];
                            slot_wd.qua    = i_s_axis_tdata[61:46];
                            n_count        = r_count + 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (r_idx == r_count) begin
                        // closing step: flush the held wake or report an idle tick
                        n_out_valid = 1'b1;
                        if (r_pend_valid) begin
                            n_out = r_pend;
                        end else begin
                            n_out      = '0;
                            n_out.kind = KIND_IDLE_TICK;
                        end
                        n_out.tick   = r_tick;
                        n_out.last   = 1'b1;
                        n_pend_valid = 1'b0;
                        n_count      = r_wr;
                        n_state      = ST_IDLE;
                    end else if (due && (r_nwoke < WOKE_W'(RESULT_CAP))) begin
                        // hold one wake back so the final one can carry last
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                            n_out.tick  = r_tick;
                            n_out.last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend       = woke;
                        n_nwoke      = r_nwoke + 1'b1;
                        n_idx        = r_idx + 1'b1;
                    end else begin
                        slot_we = 1'b1;
                        slot_wa = r_wr[IDX_W-1:0];
                        n_wr    = r_wr + 1'b1;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tick       <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_wr         <= '0;
            r_nwoke      <= '0;
            r_mode       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tick       <= n_tick;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_wr         <= n_wr;
            r_nwoke      <= n_nwoke;
            r_mode       <= n_mode;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot[slot_wa] <= slot_wd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {7'd0, r_out.tick, r_out.qua, r_out.pri, r_out.rv,
                              r_out.thread, r_out.status};

    `SWT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_SLEEPERS), "table count over capacity")
    `SWT_ASSERT(a_compact_order, i_clk, i_rst_n, (r_state == ST_SCAN) |-> (r_wr <= r_idx && r_idx <= r_count), "compaction pointer passed scan pointer")
    `SWT_ASSERT(a_no_pend_idle, i_clk, i_rst_n, (r_state == ST_IDLE) |-> !r_pend_valid, "held wake left behind after scan")
    `SWT_ASSERT(a_tick_step, i_clk, i_rst_n, (in_acc && i_s_axis_tuser == CMD_TICK) |=> (r_tick == TICK_W'($past(r_tick) + 1'b1)), "tick counter did not advance by one")
    `SWT_ASSERT_ALWAYS(a_reset_idle, i_clk, !$past(i_rst_n) |-> (r_state == ST_IDLE && !o_m_axis_tvalid), "block not idle after reset")

endmodule

[tb/sv/sleep_wakeup_table_top_test.sv]
// Self-checking testbench for the sleep/wakeup table: directed rows, then random phases.
module sleep_wakeup_table_top_test;
    import swt_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE       = 40;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 100;

    typedef struct {
        logic        cmd;
        logic [7:0]  thr;
        logic [31:0] len;
        logic [5:0]  pri;
        logic [15:0] qua;
        bit          typed;
        t_result     want;
    } t_req;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [1:0]             o_m_axis_tuser;
    logic                   o_m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data = 1'b0;

    sleep_wakeup_table_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the sleeper table, kept packed in insertion order
    logic [TICK_W-1:0] tick_now = '0;
    logic              restore_mode = 1'b0;
    int                sleepers = 0;
    logic [THR_W-1:0]  sl_thr  [MAX_SLEEPERS];
    logic [TICK_W-1:0] sl_wake [MAX_SLEEPERS];
    logic [PRI_W-1:0]  sl_pri  [MAX_SLEEPERS];
    logic [QUA_W-1:0]  sl_qua  [MAX_SLEEPERS];

    t_result replies_due[$];
    t_req    directed_rows[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      idle_on = 1'b1;
    t_result got;
    t_result want;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [47:0] g, input logic [47:0] w);
        if (g !== w)
            flag_mismatch($sformatf("%s got %0h want %0h", name, g, w));
    endtask

    // table response to one request; pushes every reply it causes
    task automatic apply_request(input t_req r);
        t_result res;
        int      w;
        int      n;
        if (r.cmd == CMD_SLEEP) begin
            res = '0;
            res.kind = KIND_SLEEP;
            res.tick = tick_now;
            res.last = 1'b1;
            if (r.len == '0) begin
                res.status = STS_ZERO;
            end else if (sleepers == MAX_SLEEPERS) begin
                res.status = STS_FULL;
            end else begin
                sl_thr[sleepers]  = r.thr;
                sl_wake[sleepers] = tick_now + TICK_W'(r.len);
                sl_pri[sleepers]  = r.pri;
                sl_qua[sleepers]  = r.qua;
                sleepers++;
                res.status = STS_OK;
            end
            replies_due.push_back(res);
        end else begin
            tick_now = tick_now + 1'b1;
            w = 0;
            n = 0;
            for (int i = 0; i < sleepers; i++) begin
                if (n < RESULT_CAP && tick_now >= sl_wake[i]) begin
                    res = '0;
                    res.kind   = KIND_WOKEN;
                    res.thread = sl_thr[i];
                    res.rv     = restore_mode;
                    res.pri    = restore_mode ? sl_pri[i] : '0;
                    res.qua    = restore_mode ? sl_qua[i] : '0;
                    res.tick   = tick_now;
                    replies_due.push_back(res);
                    n++;
                end else begin
                    sl_thr[w]  = sl_thr[i];
                    sl_wake[w] = sl_wake[i];
                    sl_pri[w]  = sl_pri[i];
                    sl_qua[w]  = sl_qua[i];
                    w++;
                end
            end
            sleepers = w;
            if (n == 0) begin
                res = '0;
                res.kind = KIND_IDLE_TICK;
                res.tick = tick_now;
                res.last = 1'b1;
                replies_due.push_back(res);
            end else begin
                res = replies_due.pop_back();
                res.last = 1'b1;
                replies_due.push_back(res);
            end
        end
    endtask

    task automatic add_row(input logic cmd, input logic [7:0] thr, input logic [31:0] len,
                           input logic [5:0] pri, input logic [15:0] qua, input bit typed,
                           input logic [1:0] kind, input logic [1:0] status,
                           input logic [47:0] tick);
        t_req r;
        r.cmd = cmd;
        r.thr = thr;
        r.len = len;
        r.pri = pri;
        r.qua = qua;
        r.typed = typed;
        r.want = '0;
        r.want.kind = kind;
        r.want.status = status;
        r.want.tick = tick;
        r.want.last = 1'b1;
        directed_rows.push_back(r);
    endtask

    task automatic send_request(input t_req r);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 7) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.cmd;
        i_s_axis_tdata  <= {2'b00, r.qua, r.pri, r.len, r.thr};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        apply_request(r);
        // typed rows carry a single reply known in advance
        if (r.typed) begin
            void'(replies_due.pop_back());
            replies_due.push_back(r.want);
        end
    endtask

    task automatic drain_replies();
        if (i_s_axis_tvalid)
            i_s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_mode(input logic v);
        drain_replies();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        restore_mode = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_request(input int tick_pct, output t_req r);
        int pick;
        r.typed = 1'b0;
        r.want  = '0;
        r.thr   = 8'($urandom_range(0, 255));
        r.pri   = 6'($urandom_range(0, 63));
        r.qua   = 16'($urandom_range(0, 65535));
        pick    = $urandom_range(0, 999);
        if ($urandom_range(0, 99) < tick_pct) begin
            r.cmd = CMD_TICK;
            r.len = $urandom();
        end else begin
            r.cmd = CMD_SLEEP;
            // long sleeps never come due, so they are kept rare
            if (pick < 60)
                r.len = '0;
            else if (pick < 67)
                r.len = $urandom();
            else if (pick < 170)
                r.len = 32'($urandom_range(13, 200));
            else
                r.len = 32'($urandom_range(1, 12));
        end
    endtask

    always @(posedge i_clk)
        i_m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 7);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind   = o_m_axis_tuser;
            got.status = o_m_axis_tdata[1:0];
            got.thread = o_m_axis_tdata[9:2];
            got.rv     = o_m_axis_tdata[10];
            got.pri    = o_m_axis_tdata[16:11];
            got.qua    = o_m_axis_tdata[32:17];
            got.tick   = o_m_axis_tdata[80:33];
            got.last   = o_m_axis_tlast;
            if (replies_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected reply kind %0d", got.kind));
            end else begin
                want = replies_due.pop_front();
                check_field("kind", 48'(got.kind), 48'(want.kind));
                check_field("status", 48'(got.status), 48'(want.status));
                check_field("woken_thread", 48'(got.thread), 48'(want.thread));
                check_field("restore_valid", 48'(got.rv), 48'(want.rv));
                check_field("restored_priority", 48'(got.pri), 48'(want.pri));
                check_field("restored_quantum", 48'(got.qua), 48'(want.qua));
                check_field("current_tick", got.tick, want.tick);
                check_field("last", 48'(got.last), 48'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sleep_wakeup_table_top: mismatch");
            $finish;
        end
    end

    initial begin
        t_req r;
        int   tick_pct [PHASES];
        logic phase_mode [PHASES];
        tick_pct   = '{30, 45, 15, 60, 40};
        phase_mode = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        add_row(CMD_SLEEP, 8'h00, 32'd0, 6'h00, 16'h0000, 1, KIND_SLEEP, STS_ZERO, 48'd0);
        add_row(CMD_TICK, 8'h00, 32'd0, 6'h00, 16'h0000, 1, KIND_IDLE_TICK, STS_OK, 48'd1);
        add_row(CMD_SLEEP, 8'hFF, 32'd1, 6'h3F, 16'hFFFF, 1, KIND_SLEEP, STS_OK, 48'd1);
        // fill the table; all come due together on the next tick, one id repeated
        for (int i = 1; i < MAX_SLEEPERS; i++)
            add_row(CMD_SLEEP, (i == 9) ? 8'hFF : 8'(i), 32'd1, 6'(i * 4), 16'(i * 4099),
                    0, KIND_SLEEP, STS_OK, 48'd0);
        add_row(CMD_SLEEP, 8'h33, 32'd5, 6'h01, 16'h0001, 1, KIND_SLEEP, STS_FULL, 48'd1);
        add_row(CMD_TICK, 8'h00, 32'd0, 6'h00, 16'h0000, 0, KIND_WOKEN, STS_OK, 48'd0);
        add_row(CMD_TICK, 8'h00, 32'd0, 6'h00, 16'h0000, 1, KIND_IDLE_TICK, STS_OK, 48'd3);
        add_row(CMD_SLEEP, 8'h5A, 32'hFFFF_FFFF, 6'h2A, 16'h5555, 1, KIND_SLEEP, STS_OK, 48'd3);
        add_row(CMD_SLEEP, 8'hA5, 32'd2, 6'h15, 16'hAAAA, 1, KIND_SLEEP, STS_OK, 48'd3);
        add_row(CMD_TICK, 8'h00, 32'd0, 6'h00, 16'h0000, 1, KIND_IDLE_TICK, STS_OK, 48'd4);
        add_row(CMD_TICK, 8'h00, 32'd0, 6'h00, 16'h0000, 0, KIND_WOKEN, STS_OK, 48'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(1'b1);
        foreach (directed_rows[k])
            send_request(directed_rows[k]);

        for (int p = 0; p < PHASES; p++) begin
            write_mode(phase_mode[p]);
            idle_on = (p != 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 59) == 0)
                    drain_replies();
                random_request(tick_pct[p], r);
                send_request(r);
            end
        end

        idle_on = 1'b1;
        drain_replies();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("sleep_wakeup_table_top: match");
        else
            $display("sleep_wakeup_table_top: mismatch");
        $finish;
    end

endmodule
